### hw/rtl/abps_pkg.sv
// ----------------------------------------------------------------------------
// Accessed-bit page-set sweeper package
// Shared sizes, request and result codes, and the types passed between the
// controller and the row of slot cells.
// ----------------------------------------------------------------------------
package abps_pkg;

  // Table size and derived widths.
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

  // Field widths of the items on the channels.
  localparam int PAGE_W  = 52;
  localparam int TAG_W   = 16;
  localparam int COUNT_W = 7;
  localparam int KIND_W  = 4;
  localparam int REQ_W   = 2;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_ACCESS = 2'd2,
    REQ_SWEEP  = 2'd3
  } req_e;

  // Result codes.
  typedef enum logic [KIND_W-1:0] {
    RK_ADDED    = 4'd0,
    RK_PRESENT  = 4'd1,
    RK_FULL     = 4'd2,
    RK_DELETED  = 4'd3,
    RK_DEL_MISS = 4'd4,
    RK_MARKED   = 4'd5,
    RK_ACC_MISS = 4'd6,
    RK_SAVE     = 4'd7,
    RK_DISCARD  = 4'd8
  } kind_e;

  // Commands broadcast to every cell in the row.
  typedef enum logic [2:0] {
    CELL_NOP   = 3'd0,
    CELL_CMP   = 3'd1,
    CELL_WRITE = 3'd2,
    CELL_CLEAR = 3'd3,
    CELL_MARK  = 3'd4,
    CELL_SHIFT = 3'd5
  } cell_op_e;

  // One tracked slot.
  typedef struct packed {
    logic              valid;
    logic              accessed;
    logic [PAGE_W-1:0] page;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Broadcast command with its key.
  typedef struct packed {
    cell_op_e          op;
    logic [PAGE_W-1:0] page;
    logic [TAG_W-1:0]  tag;
  } cell_cmd_t;

endpackage

### hw/rtl/abps_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one request item to the sweeper.
// ----------------------------------------------------------------------------
interface abps_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [51:0] page_number;
  logic [15:0] page_tag;

  modport source (output valid, output req_type, output page_number, output page_tag,
                  input ready);
  modport sink (input valid, input req_type, input page_number, input page_tag,
                output ready);
endinterface

### hw/rtl/abps_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result item from the sweeper.
// ----------------------------------------------------------------------------
interface abps_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  result_kind;
  logic [51:0] result_page;
  logic [15:0] result_tag;
  logic [6:0]  entry_count;
  logic        sweep_empty;
  logic        last_result;

  modport source (output valid, output result_kind, output result_page,
                  output result_tag, output entry_count, output sweep_empty,
                  output last_result, input ready);
  modport sink (input valid, input result_kind, input result_page,
                input result_tag, input entry_count, input sweep_empty,
                input last_result, output ready);
endinterface

### hw/rtl/abps_cell.sv
// ----------------------------------------------------------------------------
// Slot cell
// Holds one table slot. Compares its page against the broadcast key, applies
// selected updates, and takes its right neighbor's slot on a ring shift.
// ----------------------------------------------------------------------------
module abps_cell (
  input  logic                clk,
  input  logic                rst,
  input  abps_pkg::cell_cmd_t cmd,
  input  logic                sel,
  input  abps_pkg::entry_t    shift_in,
  output abps_pkg::entry_t    entry,
  output logic                hit
);
  import abps_pkg::*;

  logic              valid;
  logic              accessed;
  logic [PAGE_W-1:0] page;
  logic [TAG_W-1:0]  tag;

  // Slot state and the registered match flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      accessed <= 1'b0;
      hit      <= 1'b0;
    end else begin
      unique case (cmd.op)
        CELL_CMP: begin
          hit <= valid && (page == cmd.page);
        end
        CELL_WRITE: begin
          if (sel) begin
            valid    <= 1'b1;
            accessed <= 1'b0;
            page     <= cmd.page;
            tag      <= cmd.tag;
          end
        end
        CELL_CLEAR: begin
          if (sel) begin
            valid    <= 1'b0;
            accessed <= 1'b0;
          end
        end
        CELL_MARK: begin
          if (sel) begin
            accessed <= 1'b1;
          end
        end
        CELL_SHIFT: begin
          valid    <= shift_in.valid;
          accessed <= shift_in.accessed;
          page     <= shift_in.page;
          tag      <= shift_in.tag;
        end
        default: begin
        end
      endcase
    end
  end

  assign entry = '{valid: valid, accessed: accessed, page: page, tag: tag};

endmodule

### hw/rtl/accessed_bit_page_set_sweeper.sv
// ----------------------------------------------------------------------------
// Accessed-bit page-set sweeper
// Tracks a fixed set of pages with an accessed bit each and sweeps them.
// ----------------------------------------------------------------------------
// The table is a ring of TABLE_DEPTH slot cells. An add, delete or access item
// goes from acceptance to its result in order: it is latched, every cell
// compares its page against the key into its registered hit flag, and then
// the matching or lowest free slot is updated as the result register loads.
// A sweep rotates the whole ring once through slot 0, one slot per cycle
// while the output register is free, and emits one result for each tracked
// page as it passes the head; an empty table gives one marker item. Items
// are taken one at a time, a new one is accepted while the last result still
// waits in the output register, and any cycle in which that register is held
// stalls the work in progress. Reset empties the table with no clearing pass.
module accessed_bit_page_set_sweeper (
  input  logic       clk,
  input  logic       rst,
  abps_req_if.sink   req,
  abps_rsp_if.source rsp
);
  import abps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_EXEC  = 4'b0100,
    S_SWEEP = 4'b1000
  } state_t;

  state_t              state, state_next;
  req_e                op;
  logic [PAGE_W-1:0]   key_page;
  logic [TAG_W-1:0]    key_tag;
  logic [CNT_BITS-1:0] count, count_next;
  logic [CNT_BITS-1:0] remain, remain_next;
  logic [IDX_BITS-1:0] step, step_next;

  // Output register.
  logic                out_valid;
  kind_e               out_kind, out_kind_next;
  logic [PAGE_W-1:0]   out_page, out_page_next;
  logic [TAG_W-1:0]    out_tag, out_tag_next;
  logic                out_empty, out_empty_next;
  logic                out_last, out_last_next;
  logic [CNT_BITS-1:0] out_count;
  logic                out_load;
  logic                out_free;

  // Cell row.
  cell_cmd_t               cmd;
  logic [TABLE_DEPTH-1:0]  sel;
  logic [TABLE_DEPTH-1:0]  hit_vec;
  logic [TABLE_DEPTH-1:0]  free_vec;
  logic [TABLE_DEPTH-1:0]  low_free;
  entry_t                  cell_entry [TABLE_DEPTH];
  entry_t                  shift_in [TABLE_DEPTH];
  entry_t                  head;
  entry_t                  wrap;
  logic                    any_hit;
  logic                    any_free;
  logic [TAG_W-1:0]        hit_tag;
  logic                    accept;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;

  // The row of cells, linked as a ring toward slot 0.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    abps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .sel      (sel[i]),
      .shift_in (shift_in[i]),
      .entry    (cell_entry[i]),
      .hit      (hit_vec[i])
    );
    assign free_vec[i] = !cell_entry[i].valid;
    if (i == TABLE_DEPTH - 1) begin : g_wrap
      assign shift_in[i] = wrap;
    end else begin : g_link
      assign shift_in[i] = cell_entry[i+1];
    end
  end

  // The head slot leaves the sweep with its accessed bit cleared, or removed.
  assign head = cell_entry[0];
  always_comb begin
    wrap = head;
    if (head.valid) begin
      if (head.accessed) begin
        wrap.accessed = 1'b0;
      end else begin
        wrap.valid = 1'b0;
      end
    end
  end

  // Match summary, stored tag of the match and lowest free slot.
  assign any_hit  = |hit_vec;
  assign any_free = |free_vec;
  assign low_free = free_vec & (~free_vec + TABLE_DEPTH'(1));
  always_comb begin
    hit_tag = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_tag = hit_tag | (cell_entry[i].tag & {TAG_W{hit_vec[i]}});
    end
  end

  // Sequencer: picks the cell command and forms the next result.
  always_comb begin
    state_next     = state;
    count_next     = count;
    remain_next    = remain;
    step_next      = step;
    cmd            = '{op: CELL_NOP, page: key_page, tag: key_tag};
    sel            = '0;
    out_load       = 1'b0;
    out_kind_next  = RK_ADDED;
    out_page_next  = key_page;
    out_tag_next   = '0;
    out_empty_next = 1'b0;
    out_last_next  = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_e'(req.req_type) == REQ_SWEEP) begin
            state_next  = S_SWEEP;
            step_next   = '0;
            remain_next = count;
          end else begin
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        cmd.op     = CELL_CMP;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          unique case (op)
            REQ_ADD: begin
              if (any_hit) begin
                out_kind_next = RK_PRESENT;
                out_tag_next  = hit_tag;
              end else if (!any_free) begin
                out_kind_next = RK_FULL;
              end else begin
                cmd.op        = CELL_WRITE;
                sel           = low_free;
                count_next    = count + CNT_BITS'(1);
                out_kind_next = RK_ADDED;
                out_tag_next  = key_tag;
              end
            end
            REQ_DELETE: begin
              if (any_hit) begin
                cmd.op        = CELL_CLEAR;
                sel           = hit_vec;
                count_next    = count - CNT_BITS'(1);
                out_kind_next = RK_DELETED;
                out_tag_next  = hit_tag;
              end else begin
                out_kind_next = RK_DEL_MISS;
              end
            end
            default: begin
              if (any_hit) begin
                cmd.op        = CELL_MARK;
                sel           = hit_vec;
                out_kind_next = RK_MARKED;
                out_tag_next  = hit_tag;
              end else begin
                out_kind_next = RK_ACC_MISS;
              end
            end
          endcase
        end
      end
      S_SWEEP: begin
        if (out_free) begin
          if (step == '0 && remain == '0) begin
            // A sweep of an empty table gives a single marker item.
            out_load       = 1'b1;
            out_kind_next  = RK_ADDED;
            out_page_next  = '0;
            out_empty_next = 1'b1;
            state_next     = S_IDLE;
          end else begin
            cmd.op = CELL_SHIFT;
            if (head.valid) begin
              out_load      = 1'b1;
              out_page_next = head.page;
              out_tag_next  = head.tag;
              out_last_next = (remain == CNT_BITS'(1));
              remain_next   = remain - CNT_BITS'(1);
              if (head.accessed) begin
                out_kind_next = RK_SAVE;
              end else begin
                out_kind_next = RK_DISCARD;
                count_next    = count - CNT_BITS'(1);
              end
            end
            if (step == IDX_BITS'(TABLE_DEPTH - 1)) begin
              state_next = S_IDLE;
            end else begin
              step_next = step + IDX_BITS'(1);
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remain    <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      remain <= remain_next;
      step   <= step_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request key and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= req_e'(req.req_type);
      key_page <= req.page_number;
      key_tag  <= req.page_tag;
    end
    if (out_load) begin
      out_kind  <= out_kind_next;
      out_page  <= out_page_next;
      out_tag   <= out_tag_next;
      out_empty <= out_empty_next;
      out_last  <= out_last_next;
    end
  end

  // The count shown is the one after the result, so it follows the register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count <= count_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_kind = out_kind;
  assign rsp.result_page = out_page;
  assign rsp.result_tag  = out_tag;
  assign rsp.entry_count = COUNT_W'(out_count);
  assign rsp.sweep_empty = out_empty;
  assign rsp.last_result = out_last;

endmodule

### verif/accessed_bit_page_set_sweeper_tb.sv
// ----------------------------------------------------------------------------
// Accessed-bit page-set sweeper testbench
// Drives add, delete, access and sweep requests into the sweeper and checks
// every result item against a behavioral model of the page table. It starts
// with a short table of directed requests, then runs random episodes that fill
// the table, mix lookups on a small page pool and sweep it, while both sides
// of the handshake stall at random in all but the last phase.
// ----------------------------------------------------------------------------
module accessed_bit_page_set_sweeper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import abps_pkg::*;

  localparam int          HALF_PERIOD  = 6;
  localparam int          RESET_CYCLES = 7;
  localparam int          RANDOM_ITEMS = 314;
  localparam int          DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam longint      TIMEOUT_NS   = 64'd4_800_000;
  localparam logic [51:0] PAGE_MAX     = '1;

  // One expected result item.
  typedef struct packed {
    kind_e       kind;
    logic [51:0] page;
    logic [15:0] tag;
    logic [6:0]  count;
    logic        empty;
    logic        last;
  } result_t;

  // One directed request; the result is spelled out only where typed is set.
  typedef struct packed {
    req_e        op;
    logic [51:0] page;
    logic [15:0] tag;
    logic        typed;
    kind_e       kind;
    logic [15:0] rtag;
    logic [6:0]  count;
    logic        empty;
  } stim_row_t;

  localparam int NUM_ROWS = 16;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // Sweep of the empty table after reset gives a single empty marker with zero page and tag.
    '{REQ_SWEEP,  52'h0,              16'h0000, 1'b1, RK_ADDED,    16'h0000, 7'd0, 1'b1},
    '{REQ_DELETE, 52'h0,              16'h0000, 1'b1, RK_DEL_MISS, 16'h0000, 7'd0, 1'b0},
    '{REQ_ACCESS, PAGE_MAX,           16'hFFFF, 1'b1, RK_ACC_MISS, 16'h0000, 7'd0, 1'b0},
    '{REQ_ADD,    52'h0,              16'hFFFF, 1'b1, RK_ADDED,    16'hFFFF, 7'd1, 1'b0},
    '{REQ_ADD,    PAGE_MAX,           16'h0000, 1'b1, RK_ADDED,    16'h0000, 7'd2, 1'b0},
    // A second add keeps the stored tag and ignores the new one.
    '{REQ_ADD,    52'h0,              16'h1234, 1'b1, RK_PRESENT,  16'hFFFF, 7'd2, 1'b0},
    '{REQ_ACCESS, 52'h0,              16'h0000, 1'b1, RK_MARKED,   16'hFFFF, 7'd2, 1'b0},
    // Re-adding an accessed page must leave its accessed bit set.
    '{REQ_ADD,    52'h0,              16'h0000, 1'b0, RK_ADDED,    16'h0000, 7'd0, 1'b0},
    '{REQ_ADD,    52'h5_5555_5555_5555, 16'h5555, 1'b0, RK_ADDED,  16'h0000, 7'd0, 1'b0},
    // Open a hole in slot 1, then refill it with the lowest free slot rule.
    '{REQ_DELETE, PAGE_MAX,           16'h0000, 1'b0, RK_ADDED,    16'h0000, 7'd0, 1'b0},
    '{REQ_ADD,    52'hA_AAAA_AAAA_AAAA, 16'hAAAA, 1'b0, RK_ADDED,  16'h0000, 7'd0, 1'b0},
    '{REQ_ACCESS, 52'hA_AAAA_AAAA_AAAA, 16'h0000, 1'b0, RK_ADDED,  16'h0000, 7'd0, 1'b0},
    // Sweeps: save and discard mixed, then all discard, then empty again.
    '{REQ_SWEEP,  PAGE_MAX,           16'hFFFF, 1'b0, RK_ADDED,    16'h0000, 7'd0, 1'b0},
    '{REQ_SWEEP,  52'h0,              16'h0000, 1'b0, RK_ADDED,    16'h0000, 7'd0, 1'b0},
    '{REQ_SWEEP,  52'h0,              16'h0000, 1'b0, RK_ADDED,    16'h0000, 7'd0, 1'b0},
    '{REQ_DELETE, PAGE_MAX,           16'h0000, 1'b0, RK_ADDED,    16'h0000, 7'd0, 1'b0}
  };

  logic clk;
  logic rst;

  abps_req_if req ();
  abps_rsp_if rsp ();

  accessed_bit_page_set_sweeper u_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // Model of the page table.
  logic        trk_valid    [TABLE_DEPTH];
  logic        trk_accessed [TABLE_DEPTH];
  logic [51:0] trk_page     [TABLE_DEPTH];
  logic [15:0] trk_tag      [TABLE_DEPTH];
  int          trk_count;

  result_t pending_results[$];
  int      items_accepted;
  int      mismatch_count;

  initial begin
    clk = 1'b0;
  end

  always #HALF_PERIOD clk = ~clk;

  // Stall rates by phase: receiver-heavy, sender-heavy, then none.
  function automatic int send_idle_pct();
    if (items_accepted < 115) begin
      return 26;
    end else if (items_accepted < 230) begin
      return 64;
    end
    return 0;
  endfunction

  function automatic int recv_stall_pct();
    if (items_accepted < 115) begin
      return 64;
    end else if (items_accepted < 230) begin
      return 26;
    end
    return 0;
  endfunction

  // Applies one request to the table model and queues the results it causes.
  function automatic void model_request(req_e op, logic [51:0] page, logic [15:0] tag,
                                        bit record);
    int      hit;
    int      free_slot;
    int      total;
    int      emitted;
    result_t r;
    hit       = -1;
    free_slot = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (trk_valid[i] && trk_page[i] == page && hit < 0) hit = i;
      if (!trk_valid[i] && free_slot < 0) free_slot = i;
    end
    r.kind  = RK_ADDED;
    r.page  = page;
    r.tag   = '0;
    r.empty = 1'b0;
    r.last  = 1'b1;
    case (op)
      REQ_ADD: begin
        if (hit >= 0) begin
          r.kind = RK_PRESENT;
          r.tag  = trk_tag[hit];
        end else if (free_slot < 0) begin
          r.kind = RK_FULL;
        end else begin
          trk_valid[free_slot]    = 1'b1;
          trk_accessed[free_slot] = 1'b0;
          trk_page[free_slot]     = page;
          trk_tag[free_slot]      = tag;
          trk_count++;
          r.kind = RK_ADDED;
          r.tag  = tag;
        end
      end
      REQ_DELETE: begin
        if (hit < 0) begin
          r.kind = RK_DEL_MISS;
        end else begin
          trk_valid[hit]    = 1'b0;
          trk_accessed[hit] = 1'b0;
          trk_count--;
          r.kind = RK_DELETED;
          r.tag  = trk_tag[hit];
        end
      end
      REQ_ACCESS: begin
        if (hit < 0) begin
          r.kind = RK_ACC_MISS;
        end else begin
          trk_accessed[hit] = 1'b1;
          r.kind = RK_MARKED;
          r.tag  = trk_tag[hit];
        end
      end
      default: begin
        // Sweep: one result per tracked page, or one empty marker.
        if (trk_count == 0) begin
          r.page  = '0;
          r.empty = 1'b1;
        end else begin
          total   = trk_count;
          emitted = 0;
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (trk_valid[i]) begin
              emitted++;
              r.page = trk_page[i];
              r.tag  = trk_tag[i];
              if (trk_accessed[i]) begin
                trk_accessed[i] = 1'b0;
                r.kind = RK_SAVE;
              end else begin
                trk_valid[i] = 1'b0;
                trk_count--;
                r.kind = RK_DISCARD;
              end
              r.count = 7'(trk_count);
              r.last  = (emitted == total);
              if (record) pending_results.push_back(r);
            end
          end
          return;
        end
      end
    endcase
    r.count = 7'(trk_count);
    if (record) pending_results.push_back(r);
  endfunction

  // Presents one request, waits for it to be taken, then updates the model.
  task automatic send_request(input req_e op, input logic [51:0] page,
                              input logic [15:0] tag, input bit typed,
                              input result_t typed_result);
    if ($urandom_range(99) < send_idle_pct()) begin
      req.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct()) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.req_type    <= op;
    req.page_number <= page;
    req.page_tag    <= tag;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    model_request(op, page, tag, !typed);
    if (typed) pending_results.push_back(typed_result);
    items_accepted++;
  endtask

  task automatic send_checked(input req_e op, input logic [51:0] page,
                              input logic [15:0] tag);
    send_request(op, page, tag, 1'b0, '0);
  endtask

  function automatic logic [51:0] rand_page();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(15))
      0:       return '0;
      1:       return PAGE_MAX;
      2:       return 52'd1 << $urandom_range(51);
      default: return raw[51:0];
    endcase
  endfunction

  // Picks a tracked page when there is one at the chosen slot.
  function automatic logic [51:0] tracked_or_random();
    int i;
    i = $urandom_range(TABLE_DEPTH - 1);
    if (trk_valid[i]) return trk_page[i];
    return rand_page();
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  // Result checker.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", 64'(rsp.result_kind), 64'h0);
      end else begin
        want = pending_results.pop_front();
        if (rsp.result_kind !== want.kind)
          report_mismatch("result_kind", 64'(rsp.result_kind), 64'(want.kind));
        if (rsp.result_page !== want.page)
          report_mismatch("result_page", 64'(rsp.result_page), 64'(want.page));
        if (rsp.result_tag !== want.tag)
          report_mismatch("result_tag", 64'(rsp.result_tag), 64'(want.tag));
        if (rsp.entry_count !== want.count)
          report_mismatch("entry_count", 64'(rsp.entry_count), 64'(want.count));
        if (rsp.sweep_empty !== want.empty)
          report_mismatch("sweep_empty", 64'(rsp.sweep_empty), 64'(want.empty));
        if (rsp.last_result !== want.last)
          report_mismatch("last_result", 64'(rsp.last_result), 64'(want.last));
      end
    end
  end

  // Result ready, stalled at the rate of the current phase.
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct());
    end
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus and end of run.
  initial begin : stimulus
    result_t     lit;
    logic [51:0] pool [12];
    int          n_ops;
    int          sel;
    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.req_type    <= REQ_ADD;
    req.page_number <= '0;
    req.page_tag    <= '0;
    items_accepted  = 0;
    mismatch_count  = 0;
    trk_count       = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      trk_valid[i]    = 1'b0;
      trk_accessed[i] = 1'b0;
      trk_page[i]     = '0;
      trk_tag[i]      = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    for (int r = 0; r < NUM_ROWS; r++) begin
      lit.kind  = DIRECTED_ROWS[r].kind;
      lit.page  = (DIRECTED_ROWS[r].op == REQ_SWEEP) ? '0 : DIRECTED_ROWS[r].page;
      lit.tag   = DIRECTED_ROWS[r].rtag;
      lit.count = DIRECTED_ROWS[r].count;
      lit.empty = DIRECTED_ROWS[r].empty;
      lit.last  = 1'b1;
      send_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].page, DIRECTED_ROWS[r].tag,
                   DIRECTED_ROWS[r].typed, lit);
    end

    // Random episodes, each usually closed by a sweep.
    while (items_accepted < NUM_ROWS + RANDOM_ITEMS) begin
      case ($urandom_range(2))
        0: begin
          // Fill the table up with some accesses on the way, then overfill it.
          while (trk_count < TABLE_DEPTH) begin
            if ($urandom_range(9) < 3) begin
              send_checked(REQ_ACCESS, tracked_or_random(), 16'($urandom));
            end else begin
              send_checked(REQ_ADD, rand_page(), 16'($urandom));
            end
          end
          repeat ($urandom_range(3, 1)) begin
            send_checked(REQ_ADD, ($urandom_range(1) != 0) ? rand_page() : tracked_or_random(),
                         16'($urandom));
          end
          send_checked(REQ_SWEEP, rand_page(), 16'($urandom));
        end
        1: begin
          // Lookups on a small pool so that hits and misses both happen.
          for (int i = 0; i < 12; i++) pool[i] = rand_page();
          n_ops = $urandom_range(30, 10);
          repeat (n_ops) begin
            sel = $urandom_range(9);
            if (sel < 4) begin
              send_checked(REQ_ADD, pool[$urandom_range(11)], 16'($urandom));
            end else if (sel < 6) begin
              send_checked(REQ_DELETE, pool[$urandom_range(11)], 16'($urandom));
            end else if (sel < 9) begin
              send_checked(REQ_ACCESS, pool[$urandom_range(11)], 16'($urandom));
            end else begin
              send_checked(req_e'($urandom_range(3)), rand_page(), 16'($urandom));
            end
          end
          if ($urandom_range(4) != 0) send_checked(REQ_SWEEP, rand_page(), 16'($urandom));
        end
        default: begin
          // Mark a few tracked pages, then sweep twice so saves turn to discards.
          repeat ($urandom_range(6)) begin
            send_checked(REQ_ACCESS, tracked_or_random(), 16'($urandom));
          end
          send_checked(REQ_SWEEP, rand_page(), 16'($urandom));
          send_checked(REQ_SWEEP, rand_page(), 16'($urandom));
        end
      endcase
    end
    req.valid <= 1'b0;

    // Drain the outstanding results, then watch for stray ones.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
